// File: rtl/mpf_pkg.sv
// shared types and constants for the multilevel priority fifo
// no dependencies; imported by multilevel_priority_fifo
`default_nettype none

package mpf_pkg;

   localparam int NUM_LEVELS_DEF  = 8;
   localparam int LEVEL_DEPTH_DEF = 16;
   localparam int VALUE_WIDTH_DEF = 32;

   // item field widths and positions
   localparam int FIELD_VALUE_W = 32;
   localparam int FIELD_LEVEL_W = 3;
   localparam int FIELD_VALUE_LSB = 0;
   localparam int FIELD_LEVEL_LSB = FIELD_VALUE_LSB + FIELD_VALUE_W;
   localparam int TDATA_USED_W = FIELD_VALUE_W + FIELD_LEVEL_W;
   localparam int TDATA_W = ((TDATA_USED_W + 7) / 8) * 8;
   localparam int TDATA_PAD_W = TDATA_W - TDATA_USED_W;

   // width used to sign-extend values between storage and fields
   localparam int WIDE_W = 64;

   typedef enum logic [0:0] {
      ACTION_ENQUEUE = 1'b0,
      ACTION_DEQUEUE = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      STATUS_ENQUEUED  = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_DEQUEUED  = 2'd2,
      STATUS_UNDERFLOW = 2'd3
   } status_type;

endpackage

`default_nettype wire

// File: rtl/multilevel_priority_fifo.sv
// multilevel priority fifo: one circular fifo per level in a shared ram
// depends on mpf_pkg and mpf_ram
//
// channels: req_* takes one item per handshake, an enqueue (req_tuser low)
// of a value to a level, or a dequeue (req_tuser high). rsp_* returns one
// item per request: a status in rsp_tuser, and for a dequeue the value
// and the level it came from in rsp_tdata (zero for other statuses).
// dequeue serves the oldest value of the lowest-numbered non-empty level.
// an enqueue to a full level or to a level beyond the last is refused
// with overflow; a dequeue with all levels empty gives underflow.
// a taken request goes into the read stage, which waits for the registered
// ram read, and from there into the response register.
// throughput: one item per cycle while rsp_tready is high; the priority encoder
// over the level counts and the single ram write/read port are touched at most once per item.
// reset (synchronous) empties every level; stored values are not cleared.
// when rsp_tready is low the response holds, one more result waits in
// the read stage, and req_tready drops once both are full.
`default_nettype none

module multilevel_priority_fifo
   import mpf_pkg::*;
#(
   parameter int NUM_LEVELS  = NUM_LEVELS_DEF,
   parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [TDATA_W-1:0] req_tdata,   // item_value[31:0], item_level[34:32], zero pad
   input  wire logic [0:0]         req_tuser,   // action
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic      [TDATA_W-1:0] rsp_tdata,   // out_value[31:0], out_level[34:32], zero pad
   output logic      [1:0]         rsp_tuser    // status
);

   localparam int LVL_W  = $clog2(NUM_LEVELS);
   localparam int SLOT_W = $clog2(LEVEL_DEPTH);
   localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
   localparam int LEXT_W = ((LVL_W > FIELD_LEVEL_W) ? LVL_W : FIELD_LEVEL_W) + 1;
   localparam int RAM_DEPTH = NUM_LEVELS * (2 ** SLOT_W);
   localparam int ADDR_W = LVL_W + SLOT_W;

   // per-level fifo pointers and fill counts
   logic [SLOT_W-1:0] head_ff [NUM_LEVELS];
   logic [SLOT_W-1:0] head_in [NUM_LEVELS];
   logic [SLOT_W-1:0] tail_ff [NUM_LEVELS];
   logic [SLOT_W-1:0] tail_in [NUM_LEVELS];
   logic [CNT_W-1:0]  cnt_ff  [NUM_LEVELS];
   logic [CNT_W-1:0]  cnt_in  [NUM_LEVELS];

   // read stage, waits for the ram data
   logic                     p_valid_ff, p_valid_in;
   status_type               p_status_ff, p_status_in;
   logic [FIELD_LEVEL_W-1:0] p_level_ff, p_level_in;

   // response register
   logic                     out_valid_ff, out_valid_in;
   logic [FIELD_VALUE_W-1:0] out_value_ff, out_value_in;
   logic [FIELD_LEVEL_W-1:0] out_level_ff, out_level_in;
   status_type               out_status_ff, out_status_in;

   logic                     req_accept;
   logic                     p_advance;
   logic                     is_deq;
   logic [LEXT_W-1:0]        lvl_ext;
   logic [LVL_W-1:0]         enq_idx;
   logic                     enq_ok;
   logic                     found;
   logic [LVL_W-1:0]         deq_idx;
   logic [LEXT_W-1:0]        deq_ext;
   logic signed [FIELD_VALUE_W-1:0] in_value;
   logic signed [VALUE_WIDTH-1:0]   rd_value;
   logic signed [WIDE_W-1:0]        rd_wide;

   logic                   ram_wr_en;
   logic [ADDR_W-1:0]      ram_wr_addr;
   logic [VALUE_WIDTH-1:0] ram_wr_data;
   logic                   ram_rd_en;
   logic [ADDR_W-1:0]      ram_rd_addr;
   logic [VALUE_WIDTH-1:0] ram_rd_data;

   assign p_advance  = p_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !p_valid_ff || p_advance;
   assign req_accept = req_tvalid && req_tready;
   assign is_deq     = (req_tuser == ACTION_DEQUEUE);

   assign lvl_ext = LEXT_W'(req_tdata[FIELD_LEVEL_LSB +: FIELD_LEVEL_W]);
   assign enq_idx = lvl_ext[LVL_W-1:0];
   assign enq_ok  = (lvl_ext < LEXT_W'(NUM_LEVELS)) &&
                    (cnt_ff[enq_idx] < CNT_W'(LEVEL_DEPTH));

   // lowest-numbered non-empty level
   always_comb begin
      found   = 1'b0;
      deq_idx = '0;
      for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
         if (cnt_ff[i] != '0) begin
            found   = 1'b1;
            deq_idx = LVL_W'(i);
         end
      end
   end
   assign deq_ext = LEXT_W'(deq_idx);

   assign in_value    = req_tdata[FIELD_VALUE_LSB +: FIELD_VALUE_W];
   assign ram_wr_en   = req_accept && !is_deq && enq_ok;
   assign ram_wr_addr = {enq_idx, tail_ff[enq_idx]};
   assign ram_wr_data = VALUE_WIDTH'(WIDE_W'(in_value));
   assign ram_rd_en   = req_accept && is_deq && found;
   assign ram_rd_addr = {deq_idx, head_ff[deq_idx]};

   mpf_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (RAM_DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // pointer and count updates
   always_comb begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
         head_in[i] = head_ff[i];
         tail_in[i] = tail_ff[i];
         cnt_in[i]  = cnt_ff[i];
      end
      if (ram_wr_en) begin
         tail_in[enq_idx] = (tail_ff[enq_idx] == SLOT_W'(LEVEL_DEPTH - 1)) ?
                            '0 : tail_ff[enq_idx] + SLOT_W'(1);
         cnt_in[enq_idx]  = cnt_ff[enq_idx] + CNT_W'(1);
      end
      if (ram_rd_en) begin
         head_in[deq_idx] = (head_ff[deq_idx] == SLOT_W'(LEVEL_DEPTH - 1)) ?
                            '0 : head_ff[deq_idx] + SLOT_W'(1);
         cnt_in[deq_idx]  = cnt_ff[deq_idx] - CNT_W'(1);
      end
   end

   always_comb begin
      p_valid_in  = p_valid_ff;
      p_status_in = p_status_ff;
      p_level_in  = p_level_ff;
      if (p_advance) begin
         p_valid_in = 1'b0;
      end
      if (req_accept) begin
         p_valid_in = 1'b1;
         p_level_in = '0;
         if (is_deq) begin
            if (found) begin
               p_status_in = STATUS_DEQUEUED;
               p_level_in  = deq_ext[FIELD_LEVEL_W-1:0];
            end else begin
               p_status_in = STATUS_UNDERFLOW;
            end
         end else begin
            p_status_in = enq_ok ? STATUS_ENQUEUED : STATUS_OVERFLOW;
         end
      end
   end

   assign rd_value = ram_rd_data;
   assign rd_wide  = WIDE_W'(rd_value);

   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_value_in  = out_value_ff;
      out_level_in  = out_level_ff;
      out_status_in = out_status_ff;
      if (p_advance) begin
         out_valid_in  = 1'b1;
         out_status_in = p_status_ff;
         out_level_in  = p_level_ff;
         out_value_in  = (p_status_ff == STATUS_DEQUEUED) ?
                         rd_wide[FIELD_VALUE_W-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LEVELS; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            cnt_ff[i]  <= '0;
         end
         p_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < NUM_LEVELS; i++) begin
            head_ff[i] <= head_in[i];
            tail_ff[i] <= tail_in[i];
            cnt_ff[i]  <= cnt_in[i];
         end
         p_valid_ff   <= p_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_status_ff   <= p_status_in;
      p_level_ff    <= p_level_in;
      out_status_ff <= out_status_in;
      out_level_ff  <= out_level_in;
      out_value_ff  <= out_value_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tdata  = {{TDATA_PAD_W{1'b0}}, out_level_ff, out_value_ff};

`ifndef SYNTHESIS
   generate
      for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_cnt_chk
         a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
            cnt_ff[g] <= CNT_W'(LEVEL_DEPTH))
            else $error("level fill count beyond depth");
      end
   endgenerate

   a_rd_hold: assert property (@(posedge clock) disable iff (reset)
      p_valid_ff && !p_advance |=> $stable(ram_rd_data))
      else $error("ram read data lost while read stage stalled");

   a_enq_count: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |=> cnt_ff[$past(enq_idx)] == $past(cnt_ff[enq_idx]) + CNT_W'(1))
      else $error("enqueue did not raise the level count");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !p_valid_ff)
      else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire

// File: rtl/mpf_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module mpf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
